>>> rtl/core/dotq_pkg.sv
// Shared opcode constants and period width for the deadline ordered timer queue.
`timescale 1ns / 1ps
package dotq_pkg;
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_QUERY   = 3'd3;
    localparam logic [2:0] OP_PROCESS = 3'd4;
    localparam int PERIOD_BITS = 31;
endpackage

>>> rtl/core/deadline_ordered_timer_queue_top.sv
// Top level of the deadline ordered timer queue: list sequencer and slot stores.
// The list is walked one entry per cycle through a single shared compare/shift unit.
// One request at a time; in_stall is high in work and while out_stall holds a result.
// A finished result sits in an output register; the next request is taken no earlier than
// the cycle that result leaves. Reset: asynchronous, active low; list empty, flags cleared.
`timescale 1ns / 1ps
module deadline_ordered_timer_queue_top #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [3:0]  timer_index,
    input  logic [30:0] timeout,
    input  logic        periodic,
    input  logic        notify,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        fired,
    output logic [3:0]  fired_index,
    output logic        is_started,
    output logic [4:0]  active_count
);
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int PW = dotq_pkg::PERIOD_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;  // scan for slot position
    localparam logic [2:0] S_CLOSE = 3'd2;  // shift entries left over removed slot
    localparam logic [2:0] S_SRCH  = 3'd3;  // scan for insertion point
    localparam logic [2:0] S_OPEN  = 3'd4;  // shift entries right, drop slot in
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [TIME_BITS-1:0] dl_mem [NUM_TIMERS];
    logic [PW-1:0]        per_mem [NUM_TIMERS];
    logic [IW-1:0]        ord_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] periodic_reg, notify_reg, listed_reg;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        ins_pt_reg;          // insertion point found by the search
    logic [IW-1:0]        slot_reg, slot_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;     // deadline of slot being inserted
    logic                 ins_reg, ins_next;   // insert after removal
    logic                 fired_reg, fired_next;
    logic [3:0]           fidx_reg, fidx_next;
    logic                 qry_reg, qry_next;
    logic                 ov_reg;

    // request fields held for the whole operation
    logic [2:0]           op_reg;
    logic [IW-1:0]        idx_reg;
    logic                 idx_ok_reg;
    logic [PW-1:0]        tmo_reg;
    logic                 per_in_reg, ntf_in_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic accept;
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign fired = fired_reg;
    assign fired_index = fidx_reg;
    assign is_started = qry_reg;
    assign active_count = 5'(len_reg);

    logic [IW-1:0] pos_i;
    logic [IW-1:0] pos_m1;
    logic [IW-1:0] ord_at_pos, ord_at_prev, ord_at_next, head;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] remain;
    assign pos_i  = pos_reg[IW-1:0];
    assign pos_m1 = IW'(pos_reg - CW'(1));
    assign ord_at_pos  = ord_mem[pos_i];
    assign ord_at_prev = ord_mem[pos_m1];
    assign ord_at_next = ord_mem[IW'(pos_reg + CW'(1))];
    assign head = ord_mem[0];
    // shared compare unit: new deadline minus deadline of the scanned entry
    assign diff = dl_reg - dl_mem[ord_at_pos];
    assign remain = dl_mem[head] - now_reg;

    // order list write control
    logic          ord_we;
    logic [IW-1:0] ord_wa, ord_wd;
    logic          dl_we;

    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        pos_next = pos_reg;
        slot_next = slot_reg;
        dl_next = dl_reg;
        ins_next = ins_reg;
        fired_next = fired_reg;
        fidx_next = fidx_reg;
        qry_next = qry_reg;
        ord_we = 1'b0;
        ord_wa = pos_i;
        ord_wd = ord_at_next;
        dl_we = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fired_next = 1'b0;
                    fidx_next = 4'd0;
                    qry_next = 1'b0;
                    state_next = S_DONE;
                    pos_next = '0;
                    ins_next = 1'b0;
                    // op-specific dispatch happens next cycle from held request
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (pos_reg == '0 && !(ins_reg))
                begin
                    // first cycle: decide what to do
                    case (op_reg)
                        dotq_pkg::OP_START, dotq_pkg::OP_RESTART:
                        begin
                            if (idx_ok_reg)
                            begin
                                slot_next = idx_reg;
                                ins_next = 1'b1;
                                dl_next = now_reg + TIME_BITS'(
                                    (op_reg == dotq_pkg::OP_START) ? tmo_reg
                                                                   : per_mem[idx_reg]);
                                state_next = listed_reg[idx_reg] ? S_FIND : S_SRCH;
                            end
                            else
                                state_next = S_DONE;
                        end
                        dotq_pkg::OP_STOP:
                        begin
                            slot_next = idx_reg;
                            state_next = (idx_ok_reg && listed_reg[idx_reg]) ? S_FIND
                                                                            : S_DONE;
                            ins_next = 1'b0;
                            if (idx_ok_reg && listed_reg[idx_reg])
                                pos_next = '0;
                            // mark scan started via slot match below
                            if (idx_ok_reg && listed_reg[idx_reg] && ord_at_pos == idx_reg)
                                state_next = S_CLOSE;
                            else if (idx_ok_reg && listed_reg[idx_reg])
                                pos_next = CW'(1);
                        end
                        dotq_pkg::OP_QUERY:
                        begin
                            qry_next = idx_ok_reg && listed_reg[idx_reg];
                            state_next = S_DONE;
                        end
                        dotq_pkg::OP_PROCESS:
                        begin
                            state_next = S_DONE;
                            if (len_reg != '0 &&
                                (remain == '0 || remain[TIME_BITS-1]))
                            begin
                                slot_next = head;
                                ins_next = periodic_reg[head];
                                dl_next = now_reg + TIME_BITS'(per_mem[head]);
                                fired_next = notify_reg[head];
                                fidx_next = notify_reg[head] ? 4'(head) : 4'd0;
                                state_next = S_CLOSE; // head is at position 0
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
                else if (ord_at_pos == slot_reg)
                    state_next = S_CLOSE;
                else
                    pos_next = pos_reg + CW'(1);
            end
            S_CLOSE:
            begin
                if (pos_reg + CW'(1) < len_reg)
                begin
                    ord_we = 1'b1;
                    pos_next = pos_reg + CW'(1);
                end
                else
                begin
                    len_next = len_reg - CW'(1);
                    pos_next = '0;
                    state_next = ins_reg ? S_SRCH : S_DONE;
                end
            end
            S_SRCH:
            begin
                if (pos_reg < len_reg && !diff[TIME_BITS-1])
                    pos_next = pos_reg + CW'(1);
                else
                begin
                    dl_we = 1'b1;
                    state_next = S_OPEN;
                    slot_next = slot_reg;
                    // pos holds insertion point; walk down from len
                    pos_next = len_reg;
                    ord_wa = pos_i; // unused this cycle
                end
            end
            S_OPEN:
            begin
                // shift entries up until the insertion point is free
                if (pos_reg > ins_pt_reg)
                begin
                    ord_we = 1'b1;
                    ord_wa = pos_i;
                    ord_wd = ord_at_prev;
                    pos_next = pos_reg - CW'(1);
                end
                else
                begin
                    ord_we = 1'b1;
                    ord_wa = pos_i;
                    ord_wd = slot_reg;
                    len_next = len_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            ov_reg <= 1'b0;
            periodic_reg <= '0;
            notify_reg <= '0;
            listed_reg <= '0;
            pos_reg <= '0;
            ins_reg <= 1'b0;
            fired_reg <= 1'b0;
            fidx_reg <= '0;
            qry_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            pos_reg <= pos_next;
            ins_reg <= ins_next;
            fired_reg <= fired_next;
            fidx_reg <= fidx_next;
            qry_reg <= qry_next;
            if (state_reg == S_DONE)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (state_reg == S_FIND && pos_reg == '0 && !ins_reg &&
                op_reg == dotq_pkg::OP_START && idx_ok_reg)
            begin
                periodic_reg[idx_reg] <= per_in_reg;
                notify_reg[idx_reg] <= ntf_in_reg;
            end
            if (state_reg == S_CLOSE && state_next != S_CLOSE)
                listed_reg[slot_reg] <= 1'b0;
            if (state_reg == S_OPEN && state_next == S_DONE)
                listed_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        dl_reg <= dl_next;
        if (accept)
        begin
            op_reg <= opcode;
            idx_ok_reg <= 32'(timer_index) < NUM_TIMERS;
            idx_reg <= IW'(timer_index);
            tmo_reg <= timeout;
            per_in_reg <= periodic;
            ntf_in_reg <= notify;
            now_reg <= TIME_BITS'(now);
        end
        if (state_reg == S_SRCH && state_next == S_OPEN)
            ins_pt_reg <= pos_reg;
        if (state_reg == S_FIND && pos_reg == '0 && !ins_reg &&
            op_reg == dotq_pkg::OP_START && idx_ok_reg)
            per_mem[idx_reg] <= tmo_reg;
        if (dl_we)
            dl_mem[slot_reg] <= dl_reg;
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
    end
endmodule

>>> test/tb_deadline_ordered_timer_queue_top.sv
// Self-checking testbench for the deadline ordered timer queue: directed and random requests, predicted results.
`timescale 1ns / 1ps
module tb_deadline_ordered_timer_queue_top;

    localparam int NT = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * NT + 20;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  idx;
        logic [30:0] tmo;
        logic        per;
        logic        ntf;
        logic [31:0] tnow;
    } timer_req_t;

    typedef struct packed {
        logic       fired;
        logic [3:0] fidx;
        logic       started;
        logic [4:0] count;
    } timer_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] opcode = '0;
    logic [3:0] timer_index = '0;
    logic [30:0] timeout = '0;
    logic periodic = 1'b0;
    logic notify = 1'b0;
    logic [31:0] now = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic fired;
    logic [3:0] fired_index;
    logic is_started;
    logic [4:0] active_count;

    deadline_ordered_timer_queue_top dut (.*);

    always #6 clk = ~clk;

    // Predictor state: our own copy of the slot stores and ordered list.
    logic [31:0] pr_deadline [NT];
    logic [30:0] pr_period   [NT];
    logic        pr_periodic [NT];
    logic        pr_notify   [NT];
    int          pr_order    [$];

    timer_req_t  pending_reqs [$];
    timer_rsp_t  expected_rsps [$];

    int errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_fired = 0;
    int idle_cycles = 0;

    // Receiver hold-off control: >0 means stall for that many more cycles.
    int hold_off = 0;
    bit sender_pause = 1'b0;

    function automatic void unlink_timer(int slot);
        foreach (pr_order[i])
            if (pr_order[i] == slot)
            begin
                pr_order.delete(i);
                return;
            end
    endfunction

    function automatic void link_timer(int slot);
        int pos;
        logic [31:0] diff;
        pos = 0;
        // Goes after every entry not later than itself: equal deadlines keep order.
        while (pos < pr_order.size())
        begin
            diff = pr_deadline[slot] - pr_deadline[pr_order[pos]];
            if (diff[31])
                break;
            pos++;
        end
        pr_order.insert(pos, slot);
    endfunction

    function automatic bit is_listed(int slot);
        foreach (pr_order[i])
            if (pr_order[i] == slot)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic timer_rsp_t predict_queue_op(timer_req_t r);
        timer_rsp_t o;
        int h;
        logic [31:0] remain;
        o = '0;
        case (r.op)
            dotq_pkg::OP_START:
            begin
                unlink_timer(r.idx);
                pr_period[r.idx] = r.tmo;
                pr_periodic[r.idx] = r.per;
                pr_notify[r.idx] = r.ntf;
                pr_deadline[r.idx] = r.tnow + {1'b0, r.tmo};
                link_timer(r.idx);
            end
            dotq_pkg::OP_RESTART:
            begin
                unlink_timer(r.idx);
                pr_deadline[r.idx] = r.tnow + {1'b0, pr_period[r.idx]};
                link_timer(r.idx);
            end
            dotq_pkg::OP_STOP: unlink_timer(r.idx);
            dotq_pkg::OP_QUERY: o.started = is_listed(r.idx);
            dotq_pkg::OP_PROCESS:
                if (pr_order.size() > 0)
                begin
                    h = pr_order[0];
                    remain = pr_deadline[h] - r.tnow;
                    // Due when the signed remainder is zero or negative.
                    if (remain == 0 || remain[31])
                    begin
                        void'(pr_order.pop_front());
                        if (pr_periodic[h])
                        begin
                            pr_deadline[h] = r.tnow + {1'b0, pr_period[h]};
                            link_timer(h);
                        end
                        if (pr_notify[h])
                        begin
                            o.fired = 1'b1;
                            o.fidx = h[3:0];
                        end
                    end
                end
            default: ;
        endcase
        o.count = 5'(pr_order.size());
        return o;
    endfunction

    // Stimulus generation; restart only on slots already started.
    logic [31:0] sim_now = 32'h0;
    bit gen_ever [NT];

    function automatic timer_req_t make_req(logic [2:0] op, int idx, logic [30:0] tmo,
                                            bit per, bit ntf, logic [31:0] tn);
        timer_req_t r;
        r.op = op;
        r.idx = idx[3:0];
        r.tmo = tmo;
        r.per = per;
        r.ntf = ntf;
        r.tnow = tn;
        if (op == dotq_pkg::OP_START)
            gen_ever[idx] = 1'b1;
        return r;
    endfunction

    function automatic logic [30:0] rand_timeout();
        case ($urandom_range(0, 9))
            0: return 31'h0;
            1: return 31'h7fffffff;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 60));
        endcase
    endfunction

    function automatic timer_req_t random_req();
        int sel;
        int idx;
        logic [2:0] op;
        sel = $urandom_range(0, 99);
        idx = $urandom_range(0, NT - 1);
        // Time mostly creeps forward so timers actually expire; sometimes jumps.
        if ($urandom_range(0, 19) == 0)
            sim_now = $urandom;
        else
            sim_now = sim_now + $urandom_range(0, 8);
        if (sel < 30)
            op = dotq_pkg::OP_START;
        else if (sel < 40)
            op = dotq_pkg::OP_RESTART;
        else if (sel < 50)
            op = dotq_pkg::OP_STOP;
        else if (sel < 60)
            op = dotq_pkg::OP_QUERY;
        else if (sel < 97)
            op = dotq_pkg::OP_PROCESS;
        else
            op = 3'($urandom_range(5, 7));
        if (op == dotq_pkg::OP_RESTART && !gen_ever[idx])
            op = dotq_pkg::OP_START;
        return make_req(op, idx, rand_timeout(), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) != 0, sim_now);
    endfunction

    // Driver: presents requests from the pending queue with random gaps.
    int gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                n_accepted++;
            if (!in_valid || !in_stall)
            begin
                if (in_valid && !in_stall)
                    void'(pending_reqs.pop_front());
                if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !sender_pause)
                begin
                    in_valid <= 1'b1;
                    opcode <= pending_reqs[0].op;
                    timer_index <= pending_reqs[0].idx;
                    timeout <= pending_reqs[0].tmo;
                    periodic <= pending_reqs[0].per;
                    notify <= pending_reqs[0].ntf;
                    now <= pending_reqs[0].tnow;
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap = $urandom_range(1, 3);
                        3: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
                        default: gap = 0;
                    endcase
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Predictions are made when a request is accepted, in acceptance order.
    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            expected_rsps.push_back(predict_queue_op({opcode, timer_index, timeout,
                                                      periodic, notify, now}));

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        timer_rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (fired)
                n_fired++;
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result fired=%0b idx=%0d started=%0b count=%0d",
                         $time, fired, fired_index, is_started, active_count);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (fired !== want.fired)
                begin
                    errors++;
                    $display("%0t: fired expected %0b actual %0b", $time, want.fired, fired);
                end
                if (fired_index !== want.fidx)
                begin
                    errors++;
                    $display("%0t: fired_index expected %0d actual %0d",
                             $time, want.fidx, fired_index);
                end
                if (is_started !== want.started)
                begin
                    errors++;
                    $display("%0t: is_started expected %0b actual %0b",
                             $time, want.started, is_started);
                end
                if (active_count !== want.count)
                begin
                    errors++;
                    $display("%0t: active_count expected %0d actual %0d",
                             $time, want.count, active_count);
                end
            end
        end
    end

    // Receiver stall: random short stalls, now and then a long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off--;
            out_stall <= 1'b1;
        end
        else
            case ($urandom_range(0, 19))
                0, 1, 2, 3: out_stall <= 1'b1;
                4: out_stall <= ($urandom_range(0, 7) == 0);
                5:
                begin
                    out_stall <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        hold_off = $urandom_range(20, 60);
                end
                default: out_stall <= 1'b0;
            endcase
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        for (k = 0; k < NT; k++)
        begin
            gen_ever[k] = 1'b0;
            pr_deadline[k] = '0;
            pr_period[k] = '0;
            pr_periodic[k] = 1'b0;
            pr_notify[k] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-list process and query, extremes, every opcode.
        pending_reqs.push_back(make_req(dotq_pkg::OP_PROCESS, 0, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(dotq_pkg::OP_QUERY, 15, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(dotq_pkg::OP_STOP, 3, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(dotq_pkg::OP_START, 0, 31'h7fffffff, 1, 1,
                                        32'hffffffff));
        pending_reqs.push_back(make_req(dotq_pkg::OP_START, 15, 31'h0, 0, 1, 32'hffffffff));
        pending_reqs.push_back(make_req(dotq_pkg::OP_START, 5, 31'h0, 1, 0, 32'hffffffff));
        pending_reqs.push_back(make_req(dotq_pkg::OP_QUERY, 15, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(dotq_pkg::OP_PROCESS, 0, 0, 0, 0, 32'hfffffffe));
        pending_reqs.push_back(make_req(dotq_pkg::OP_PROCESS, 0, 0, 0, 0, 32'hffffffff));
        pending_reqs.push_back(make_req(dotq_pkg::OP_PROCESS, 0, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(dotq_pkg::OP_RESTART, 0, 0, 0, 0, 32'h80000000));
        pending_reqs.push_back(make_req(dotq_pkg::OP_RESTART, 15, 0, 0, 0, 32'h7fffffff));
        pending_reqs.push_back(make_req(dotq_pkg::OP_STOP, 15, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(dotq_pkg::OP_STOP, 15, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(3'd5, 1, 31'h7fffffff, 1, 1, 32'hffffffff));
        pending_reqs.push_back(make_req(3'd7, 2, 0, 0, 0, 32'h0));
        pending_reqs.push_back(make_req(dotq_pkg::OP_START, 7, 31'h55555555, 0, 1,
                                        32'haaaaaaaa));
        pending_reqs.push_back(make_req(dotq_pkg::OP_START, 8, 31'h2aaaaaaa, 1, 1,
                                        32'h55555555));
        for (k = 0; k < NT; k++)
            pending_reqs.push_back(make_req(dotq_pkg::OP_START, k, 31'd10, k[0], 1, 32'd100));
        wait_drained();

        // Sender pauses until every result is in, then a long receiver hold-off.
        sender_pause = 1'b1;
        wait_drained();
        sim_now = 32'd100;
        for (k = 0; k < 30; k++)
            pending_reqs.push_back(random_req());
        hold_off = 300;
        sender_pause = 1'b0;

        for (k = 0; k < 1600; k++)
        begin
            pending_reqs.push_back(random_req());
            while (pending_reqs.size() > 8)
                @(posedge clk);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests through start/restart/stop/query/process;", n_accepted);
        $display("%0d results checked, %0d timer expiries reported.", n_results, n_fired);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
